// File: hdl/rcd_pkg.sv
package rcd_pkg;

  localparam int unsigned CHUNK_SIZE_W = 24;
  localparam int unsigned STREAM_ID_W  = 17;

  localparam logic [CHUNK_SIZE_W-1:0] CHUNK_SIZE_RESET = 24'd128;

  // Basic header stream id codes
  localparam logic [5:0] ID_ONE_BYTE = 6'd0;
  localparam logic [5:0] ID_TWO_BYTE = 6'd1;
  localparam logic [STREAM_ID_W-1:0] ID_OFFSET = 17'd64;

  // Message header formats
  localparam logic [1:0] FMT_FULL      = 2'd0;
  localparam logic [1:0] FMT_NO_STREAM = 2'd1;
  localparam logic [1:0] FMT_DELTA     = 2'd2;
  localparam logic [1:0] FMT_NONE      = 2'd3;

  localparam logic [23:0] TS_EXTENDED = 24'hFFFFFF;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [STREAM_ID_W-1:0]  chunk_stream;
    logic [31:0]             msg_time;
    logic [23:0]             msg_length;
    logic [7:0]              msg_kind;
    logic [31:0]             msg_stream;
    logic [CHUNK_SIZE_W-1:0] payload_count;
    logic [7:0]              payload_byte;
    logic                    chunk_end;
    logic                    message_end;
  } rec_t;

endpackage

// File: hdl/rcd_ifs.sv
interface rcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface rcd_rec_if;
  logic         valid;
  logic         ready;
  rcd_pkg::rec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rcd_parser.sv
module rcd_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  logic [7:0]                           stream_byte,
  input  logic                                 cfg_we,
  input  logic [rcd_pkg::CHUNK_SIZE_W-1:0]     cfg_wdata,
  output logic                                 res_valid,
  output rcd_pkg::rec_t                        res
);

  typedef enum logic [2:0] {
    PH_BASIC,
    PH_ID1,
    PH_ID2A,
    PH_ID2B,
    PH_MSG,
    PH_EXT,
    PH_DATA
  } phase_t;

  localparam logic [3:0] LAST_FULL      = 4'd11;
  localparam logic [3:0] LAST_NO_STREAM = 4'd7;
  localparam logic [3:0] LAST_DELTA     = 4'd3;
  localparam logic [3:0] EXT_BYTES      = 4'd4;
  localparam logic [3:0] TIME_BYTES     = 4'd3;
  localparam logic [3:0] LENGTH_END     = 4'd6;

  logic [23:0] chunk_size;

  phase_t      phase, phase_next;
  logic [3:0]  field_index, field_index_next;
  logic [1:0]  header_format, header_format_next;
  logic [16:0] current_stream_id, current_stream_id_next;
  logic [31:0] time_field, time_field_next;
  logic [31:0] prev_timestamp, prev_timestamp_next;
  logic [23:0] prev_length, prev_length_next;
  logic [7:0]  prev_type, prev_type_next;
  logic [31:0] prev_stream, prev_stream_next;
  logic [23:0] message_remaining, message_remaining_next;
  logic [23:0] chunk_remaining, chunk_remaining_next;

  logic        basic_done;
  logic        finish;
  logic        emit;
  logic [23:0] eff_size;
  logic [3:0]  last_idx;
  logic        ce;
  logic        me;

  always_comb begin
    phase_next             = phase;
    field_index_next       = field_index;
    header_format_next     = header_format;
    current_stream_id_next = current_stream_id;
    time_field_next        = time_field;
    prev_timestamp_next    = prev_timestamp;
    prev_length_next       = prev_length;
    prev_type_next         = prev_type;
    prev_stream_next       = prev_stream;
    message_remaining_next = message_remaining;
    chunk_remaining_next   = chunk_remaining;
    basic_done             = 1'b0;
    finish                 = 1'b0;
    emit                   = 1'b0;
    ce                     = 1'b0;
    me                     = 1'b0;
    eff_size               = (chunk_size == '0) ? 24'd1 : chunk_size;

    case (header_format)
      rcd_pkg::FMT_FULL:      last_idx = LAST_FULL;
      rcd_pkg::FMT_NO_STREAM: last_idx = LAST_NO_STREAM;
      default:                last_idx = LAST_DELTA;
    endcase

    case (phase)
      PH_BASIC: begin
        header_format_next = stream_byte[7:6];
        if (stream_byte[5:0] == rcd_pkg::ID_ONE_BYTE) begin
          phase_next = PH_ID1;
        end else if (stream_byte[5:0] == rcd_pkg::ID_TWO_BYTE) begin
          phase_next = PH_ID2A;
        end else begin
          current_stream_id_next = {11'd0, stream_byte[5:0]};
          basic_done             = 1'b1;
        end
      end
      PH_ID1: begin
        current_stream_id_next = {9'd0, stream_byte} + rcd_pkg::ID_OFFSET;
        basic_done             = 1'b1;
      end
      PH_ID2A: begin
        current_stream_id_next = {9'd0, stream_byte} + rcd_pkg::ID_OFFSET;
        phase_next             = PH_ID2B;
      end
      PH_ID2B: begin
        current_stream_id_next = current_stream_id + {1'b0, stream_byte, 8'd0};
        basic_done             = 1'b1;
      end
      PH_MSG: begin
        if (field_index < TIME_BYTES) begin
          time_field_next = {8'd0, time_field[15:0], stream_byte};
        end else if (field_index < LENGTH_END) begin
          prev_length_next = {prev_length[15:0], stream_byte};
        end else if (field_index == LENGTH_END) begin
          prev_type_next = stream_byte;
        end else begin
          // stream id is little-endian
          prev_stream_next = {stream_byte, prev_stream[31:8]};
        end
        field_index_next = field_index + 4'd1;
        if (field_index_next == last_idx) begin
          if (time_field_next == {8'd0, rcd_pkg::TS_EXTENDED}) begin
            phase_next       = PH_EXT;
            field_index_next = '0;
            time_field_next  = '0;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_EXT: begin
        time_field_next  = {time_field[23:0], stream_byte};
        field_index_next = field_index + 4'd1;
        if (field_index_next == EXT_BYTES) begin
          finish = 1'b1;
        end
      end
      PH_DATA: begin
        if (chunk_remaining != '0) begin
          chunk_remaining_next = chunk_remaining - 24'd1;
        end
        if (message_remaining != '0) begin
          message_remaining_next = message_remaining - 24'd1;
        end
        ce   = (chunk_remaining_next == '0);
        me   = (message_remaining_next == '0);
        emit = 1'b1;
        if (ce) begin
          phase_next       = PH_BASIC;
          field_index_next = '0;
        end
      end
      default: begin
        phase_next       = PH_BASIC;
        field_index_next = '0;
      end
    endcase

    if (basic_done) begin
      if (header_format_next == rcd_pkg::FMT_NONE) begin
        finish = 1'b1;
      end else begin
        phase_next       = PH_MSG;
        field_index_next = '0;
        time_field_next  = '0;
      end
    end

    if (finish) begin
      if (header_format_next == rcd_pkg::FMT_FULL) begin
        prev_timestamp_next = time_field_next;
      end else if (header_format_next != rcd_pkg::FMT_NONE) begin
        prev_timestamp_next = prev_timestamp + time_field_next;
      end
      // start a new message unless a continuation header finds bytes left
      if (header_format_next == rcd_pkg::FMT_FULL ||
          header_format_next == rcd_pkg::FMT_NO_STREAM ||
          message_remaining == '0) begin
        message_remaining_next = prev_length_next;
      end
      chunk_remaining_next = (message_remaining_next < eff_size) ?
                             message_remaining_next : eff_size;
      phase_next       = (chunk_remaining_next != '0) ? PH_DATA : PH_BASIC;
      field_index_next = '0;
      emit             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size        <= rcd_pkg::CHUNK_SIZE_RESET;
      phase             <= PH_BASIC;
      field_index       <= '0;
      header_format     <= '0;
      current_stream_id <= '0;
      time_field        <= '0;
      prev_timestamp    <= '0;
      prev_length       <= '0;
      prev_type         <= '0;
      prev_stream       <= '0;
      message_remaining <= '0;
      chunk_remaining   <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        chunk_size <= cfg_wdata;
      end
      res_valid <= take && emit;
      if (take) begin
        phase             <= phase_next;
        field_index       <= field_index_next;
        header_format     <= header_format_next;
        current_stream_id <= current_stream_id_next;
        time_field        <= time_field_next;
        prev_timestamp    <= prev_timestamp_next;
        prev_length       <= prev_length_next;
        prev_type         <= prev_type_next;
        prev_stream       <= prev_stream_next;
        message_remaining <= message_remaining_next;
        chunk_remaining   <= chunk_remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res.kind          <= finish ? rcd_pkg::KIND_HEADER : rcd_pkg::KIND_PAYLOAD;
      res.chunk_stream  <= current_stream_id_next;
      res.msg_time      <= prev_timestamp_next;
      res.msg_length    <= prev_length_next;
      res.msg_kind      <= prev_type_next;
      res.msg_stream    <= prev_stream_next;
      res.payload_count <= finish ? chunk_remaining_next : '0;
      res.payload_byte  <= finish ? 8'd0 : stream_byte;
      res.chunk_end     <= ce;
      res.message_end   <= me;
    end
  end

endmodule

// File: hdl/rcd_skid.sv
module rcd_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  rcd_pkg::rec_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output rcd_pkg::rec_t dn_data
);

  logic          main_valid;
  logic          skid_valid;
  rcd_pkg::rec_t main_data;
  rcd_pkg::rec_t skid_data;
  logic          dn_fire;

  // up_valid is the parser's registered result, so a byte taken now lands here
  // next cycle; keep room for it as well as for the item already on its way
  assign up_ready = !skid_valid && !(main_valid && up_valid && !dn_ready);
  assign dn_valid = main_valid;
  assign dn_data  = main_data;
  assign dn_fire  = main_valid && dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (dn_fire) begin
      if (skid_valid) begin
        // drain the skid slot; no push can happen while it is full
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (up_valid) begin
        main_data <= up_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (up_valid && !skid_valid) begin
      if (main_valid) begin
        skid_data  <= up_data;
        skid_valid <= 1'b1;
      end else begin
        main_data  <= up_data;
        main_valid <= 1'b1;
      end
    end
  end

endmodule

// File: hdl/rtmp_chunk_deframer_top.sv
// Channel   Dir  Payload                              Handshake
// in_ch     in   stream_byte (8)                      valid/ready
// out_ch    out  data: kind .. message_end (rec_t)    valid/ready
// cfg       in   cfg_wdata = chunk_size (24)          cfg_we, no ready
//
// One stream byte is taken every cycle while the output buffer has room.
// A result (header record or payload byte) for a byte is registered in the parser,
// then held in the output buffer's main entry, which drives out_ch.
// The two-entry output buffer takes the result in flight when out_ch stalls;
// in_ch ready drops in a stall cycle with a result in flight or both entries
// full. Synchronous reset sets chunk_size to 128 and returns to the basic header.
module rtmp_chunk_deframer_top (
  input  logic                             clk,
  input  logic                             rst,
  rcd_byte_if.sink                         in_ch,
  rcd_rec_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [rcd_pkg::CHUNK_SIZE_W-1:0] cfg_wdata
);

  logic          take;
  logic          buf_ready;
  logic          res_valid;
  rcd_pkg::rec_t res;

  assign in_ch.ready = buf_ready;
  assign take        = in_ch.valid && buf_ready;

  rcd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .stream_byte (in_ch.stream_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  rcd_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (res_valid),
    .up_ready (buf_ready),
    .up_data  (res),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_ch.data)
  );

endmodule
